@@ hw/rtl/htfd_pkg.sv @@
// Shared types, constants and the CRC-8 byte step for the frame decoder.
package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [2:0]  POS_FIRST   = 3'd0;
    localparam logic [2:0]  POS_LAST    = 3'd6;
    localparam logic [20:0] TEMP_OFFSET = 21'd204800;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_CRC_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic        hit;
        logic        busy;
        logic        crc_bad;
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
    } frame_t;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/htfd_frame_tracker.sv @@
// Frame position, running CRC, busy flag and raw reading assembly.
module htfd_frame_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output htfd_pkg::frame_t    frame
);
    import htfd_pkg::*;

    logic [2:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_eff;
    logic        busy_reg, busy_next;
    logic [19:0] hum_reg, hum_next;
    logic [19:0] temp_reg, temp_next;
    logic        restart;

    always_comb
    begin
        restart   = frame_start || (pos_reg > POS_LAST);
        pos_eff   = restart ? POS_FIRST : pos_reg;
        crc_eff   = restart ? CRC_INIT : crc_reg;
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        busy_next = busy_reg;
        hum_next  = hum_reg;
        temp_next = temp_reg;

        frame.hit      = enable && (pos_eff == POS_LAST);
        frame.busy     = busy_reg;
        frame.crc_bad  = crc_eff != data_byte;
        frame.hum_raw  = hum_reg;
        frame.temp_raw = temp_reg;

        if (enable)
        begin
            if (pos_eff == POS_LAST)
            begin
                pos_next = POS_FIRST;
                crc_next = CRC_INIT;
            end
            else
            begin
                unique case (pos_eff)
                    3'd0: busy_next = data_byte[7];
                    3'd1: hum_next  = {data_byte, 12'd0};
                    3'd2: hum_next  = hum_reg | {8'd0, data_byte, 4'd0};
                    3'd3:
                    begin
                        hum_next  = hum_reg | {16'd0, data_byte[7:4]};
                        temp_next = {data_byte[3:0], 16'd0};
                    end
                    3'd4: temp_next = temp_reg | {4'd0, data_byte, 8'd0};
                    default: temp_next = temp_reg | {12'd0, data_byte};
                endcase
                crc_next = crc_step(crc_eff, data_byte);
                pos_next = pos_eff + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_FIRST;
            crc_reg  <= CRC_INIT;
            busy_reg <= 1'b0;
            hum_reg  <= 20'd0;
            temp_reg <= 20'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            busy_reg <= busy_next;
            hum_reg  <= hum_next;
            temp_reg <= temp_next;
        end
    end

endmodule

@@ hw/rtl/htfd_scaler.sv @@
// Status decision and fixed-point scaling of the raw readings.
module htfd_scaler (
    input  htfd_pkg::frame_t    frame,
    output htfd_pkg::status_t   status,
    output logic [18:0]         humidity_q12,
    output logic signed [20:0]  temperature_q12
);
    import htfd_pkg::*;

    logic [26:0] hum_prod;
    logic [27:0] temp_prod;
    logic [20:0] temp_diff;

    always_comb
    begin
        hum_prod  = {7'd0, frame.hum_raw} * 27'd100;
        temp_prod = {8'd0, frame.temp_raw} * 28'd200;
        temp_diff = {1'b0, temp_prod[27:8]} - TEMP_OFFSET;

        priority if (frame.busy)
        begin
            status = STATUS_BUSY;
        end
        else if (frame.crc_bad)
        begin
            status = STATUS_CRC_ERR;
        end
        else
        begin
            status = STATUS_OK;
        end

        if (status == STATUS_OK)
        begin
            humidity_q12    = hum_prod[26:8];
            temperature_q12 = signed'(temp_diff);
        end
        else
        begin
            humidity_q12    = 19'd0;
            temperature_q12 = 21'sd0;
        end
    end

endmodule

@@ hw/rtl/humidity_temp_frame_decoder_unit.sv @@
// Top level of the humidity and temperature frame decoder.
//
// Input channel: in_valid, in_stall, data_byte, frame_start. One word is one
// byte of the seven-byte sensor frame; frame_start marks the status byte.
// Output channel: out_valid, out_stall, status, humidity_q12, temperature_q12.
// One result word leaves per frame, after the checksum byte.
//
// Throughput: one byte per cycle while in_stall is low. Each byte is held in
// the input register, then the CRC byte step, field assembly and constant
// multiplies run combinationally into the result register, so a result is
// offered once its checksum byte has passed the input and result registers.
//
// Reset clears both pipeline valids, returns the frame position to the first
// byte and the CRC to 0xFF. While the receiver stalls a waiting result, the
// block still takes one byte into its input register and then stalls the
// sender until the result register frees.
module humidity_temp_frame_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output logic                out_valid,
    input  logic                out_stall,
    output htfd_pkg::status_t   status,
    output logic [18:0]         humidity_q12,
    output logic signed [20:0]  temperature_q12
);
    import htfd_pkg::*;

    logic               a_valid_reg;
    logic [7:0]         a_byte_reg;
    logic               a_start_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [18:0]        hum_reg;
    logic signed [20:0] temp_reg;

    logic               out_free;
    logic               advance;
    frame_t             frame;
    status_t            status_c;
    logic [18:0]        hum_c;
    logic signed [20:0] temp_c;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = a_valid_reg && !out_free;
    assign advance  = a_valid_reg && out_free;

    htfd_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (advance),
        .data_byte   (a_byte_reg),
        .frame_start (a_start_reg),
        .frame       (frame)
    );

    htfd_scaler u_scaler (
        .frame           (frame),
        .status          (status_c),
        .humidity_q12    (hum_c),
        .temperature_q12 (temp_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                a_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= frame.hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            a_byte_reg  <= data_byte;
            a_start_reg <= frame_start;
        end
        if (frame.hit)
        begin
            status_reg <= status_c;
            hum_reg    <= hum_c;
            temp_reg   <= temp_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign humidity_q12    = hum_reg;
    assign temperature_q12 = temp_reg;

endmodule
